[src/dual_servo_pid_drive_assert.svh]
// ----------------------------------------------------------------------------
// dual_servo_pid_drive assertion macros
// Short forms for the concurrent checks at the end of the drive top level.
// ----------------------------------------------------------------------------
`ifndef DUAL_SERVO_PID_DRIVE_ASSERT_SVH
`define DUAL_SERVO_PID_DRIVE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define DSPD_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dual_servo_pid_drive check failed");

// next-cycle implication, quiet during reset
`define DSPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dual_servo_pid_drive check failed");

`endif

[src/dspd_pkg.sv]
// ----------------------------------------------------------------------------
// dspd_pkg
// Direction codes, register indexes, fixed widths and reset defaults of the servo PID drive.
// ----------------------------------------------------------------------------
package dspd_pkg;

  localparam int GAIN_W    = 16;
  localparam int INTEG_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    DIR_LEFT       = 3'd0,
    DIR_FORWARD    = 3'd1,
    DIR_RIGHT      = 3'd2,
    DIR_REVERSE    = 3'd3,
    DIR_SHARP_LEFT = 3'd4,
    DIR_SHARP_RIGHT = 3'd5,
    DIR_HOLD       = 3'd6,
    DIR_HOLD_ALT   = 3'd7
  } dir_t;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX  = 3'd4;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd3564;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd41;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd410;
  localparam int PULSE_MIN_RST = 1050;
  localparam int PULSE_MAX_RST = 1950;
  localparam int PULSE_HOME    = 1500;

endpackage

[src/dual_servo_pid_drive.sv]
// An accepted item reaches the output through the input register and then the result register.
// Throughput: one item per cycle while out_stall is low; the PID loop closes through the state.
// Both wheels run in parallel: six gain multipliers, each 17 by 25 or 26 bits signed.
// Reset (rst, synchronous): gains and limits return to defaults, positions to 1500,
// integrals, last errors and targets to zero, last direction to forward; no clearing pass.
// ----------------------------------------------------------------------------
// dual_servo_pid_drive
// Two-wheel servo drive: per tick a direction code sets targets and a fixed-point PID per wheel
// (left, forward, right) or the bare target yields the new clamped pulse widths; hold keeps all.
// ----------------------------------------------------------------------------
`include "dual_servo_pid_drive_assert.svh"

module dual_servo_pid_drive
  import dspd_pkg::*;
#(
  parameter int FRAC_BITS  = 12,
  parameter int PULSE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            drive_dir,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PULSE_BITS-1:0] left_pulse,
  output logic [PULSE_BITS-1:0] right_pulse,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int POS_W = PULSE_BITS + FRAC_BITS;
  localparam int ERR_W = POS_W + 1;
  localparam int W     = ERR_W + GAIN_W + 2;
  localparam logic [POS_W-1:0] POS_RST = POS_W'(PULSE_HOME) << FRAC_BITS;
  localparam logic signed [W-1:0] INT_MAX_W = W'({1'b0, {(INTEG_W-1){1'b1}}});
  localparam logic signed [W-1:0] INT_MIN_W = -INT_MAX_W - W'(1);

  // configuration
  logic [GAIN_W-1:0]     prop_gain, integ_gain, deriv_gain;
  logic [PULSE_BITS-1:0] pulse_min, pulse_max;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= PROP_GAIN_RST;
      integ_gain <= INTEG_GAIN_RST;
      deriv_gain <= DERIV_GAIN_RST;
      pulse_min  <= PULSE_BITS'(PULSE_MIN_RST);
      pulse_max  <= PULSE_BITS'(PULSE_MAX_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  prop_gain  <= cfg_data;
        REG_INTEG_GAIN: integ_gain <= cfg_data;
        REG_DERIV_GAIN: deriv_gain <= cfg_data;
        REG_PULSE_MIN:  pulse_min  <= cfg_data[PULSE_BITS-1:0];
        REG_PULSE_MAX:  pulse_max  <= cfg_data[PULSE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register and handshake
  logic s1_valid;
  dir_t s1_dir;
  logic fire;

  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_dir <= dir_t'(drive_dir);
    end
  end

  // wheel state, index 0 left, 1 right
  logic [POS_W-1:0]          pos      [2];
  logic signed [INTEG_W-1:0] integ    [2];
  logic signed [ERR_W-1:0]   lerr     [2];
  logic [PULSE_BITS-1:0]     target   [2];
  dir_t                      last_dir;

  logic [POS_W-1:0]          pos_next   [2];
  logic signed [INTEG_W-1:0] integ_next [2];
  logic signed [ERR_W-1:0]   err        [2];
  logic [PULSE_BITS-1:0]     tgt_next   [2];

  // direction decode
  logic upd_tgt, pid_mode, is_hold;
  logic sel_min [2];

  always_comb begin
    upd_tgt    = 1'b1;
    pid_mode   = 1'b0;
    is_hold    = 1'b0;
    sel_min[0] = 1'b0;
    sel_min[1] = 1'b0;
    unique case (s1_dir)
      DIR_LEFT: begin
        pid_mode = 1'b1;
        sel_min[0] = 1'b1;
      end
      DIR_FORWARD: begin
        pid_mode = 1'b1;
      end
      DIR_RIGHT: begin
        pid_mode = 1'b1;
        sel_min[1] = 1'b1;
      end
      DIR_REVERSE: begin
        sel_min[0] = 1'b1;
        sel_min[1] = 1'b1;
      end
      DIR_SHARP_LEFT: begin
        sel_min[0] = 1'b1;
      end
      DIR_SHARP_RIGHT: begin
        sel_min[1] = 1'b1;
      end
      DIR_HOLD, DIR_HOLD_ALT: begin
        upd_tgt = 1'b0;
        is_hold = 1'b1;
      end
      default: begin
        upd_tgt = 1'b0;
        is_hold = 1'b1;
      end
    endcase
  end

  logic dir_change;
  assign dir_change = (s1_dir != last_dir);

  logic signed [GAIN_W:0] kp_s, ki_s, kd_s;
  logic signed [W-1:0]    lo_fix, hi_fix;

  assign kp_s   = signed'({1'b0, prop_gain});
  assign ki_s   = signed'({1'b0, integ_gain});
  assign kd_s   = signed'({1'b0, deriv_gain});
  assign lo_fix = W'(signed'({1'b0, pulse_min, {FRAC_BITS{1'b0}}}));
  assign hi_fix = W'(signed'({1'b0, pulse_max, {FRAC_BITS{1'b0}}}));

  for (genvar w = 0; w < 2; w++) begin : g_wheel
    logic signed [ERR_W:0]          dif;
    logic signed [GAIN_W+ERR_W:0]   p_prod, i_prod;
    logic signed [GAIN_W+ERR_W+1:0] d_prod;
    logic signed [W-1:0]            p_term, i_term, d_term;
    logic signed [W-1:0]            integ_base, i_sum;
    logic signed [W-1:0]            tgt_fix, pos_sum, cand, clamped;

    assign tgt_next[w] = upd_tgt ? (sel_min[w] ? pulse_min : pulse_max) : target[w];
    assign tgt_fix     = W'(signed'({1'b0, tgt_next[w], {FRAC_BITS{1'b0}}}));
    assign err[w]      = signed'({1'b0, tgt_next[w], {FRAC_BITS{1'b0}}})
                       - signed'({1'b0, pos[w]});
    assign dif         = (ERR_W+1)'(err[w]) - (ERR_W+1)'(lerr[w]);

    assign p_prod = kp_s * err[w];
    assign i_prod = ki_s * err[w];
    assign d_prod = kd_s * dif;

    // arithmetic shift gives floor rounding
    assign p_term = W'(p_prod >>> FRAC_BITS);
    assign i_term = W'(i_prod >>> FRAC_BITS);
    assign d_term = W'(d_prod >>> FRAC_BITS);

    assign integ_base = dir_change ? '0 : W'(integ[w]);
    assign i_sum      = integ_base + i_term;

    always_comb begin
      if (i_sum > INT_MAX_W) begin
        integ_next[w] = INT_MAX_W[INTEG_W-1:0];
      end else if (i_sum < INT_MIN_W) begin
        integ_next[w] = INT_MIN_W[INTEG_W-1:0];
      end else begin
        integ_next[w] = i_sum[INTEG_W-1:0];
      end
    end

    assign pos_sum = tgt_fix + p_term + W'(integ_next[w]) + d_term;
    assign cand    = pid_mode ? pos_sum : tgt_fix;

    // lower limit checked first, so inverted limits still land on one of them
    always_comb begin
      priority if (cand < lo_fix) begin
        clamped = lo_fix;
      end else if (cand > hi_fix) begin
        clamped = hi_fix;
      end else begin
        clamped = cand;
      end
    end

    assign pos_next[w] = is_hold ? pos[w] : clamped[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        pos[i]    <= POS_RST;
        integ[i]  <= '0;
        lerr[i]   <= '0;
        target[i] <= '0;
      end
      last_dir <= DIR_FORWARD;
    end else if (fire) begin
      for (int i = 0; i < 2; i++) begin
        pos[i]    <= pos_next[i];
        integ[i]  <= integ_next[i];
        lerr[i]   <= err[i];
        target[i] <= tgt_next[i];
      end
      last_dir <= s1_dir;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      left_pulse  <= pos_next[0][POS_W-1 -: PULSE_BITS];
      right_pulse <= pos_next[1][POS_W-1 -: PULSE_BITS];
    end
  end

  `DSPD_ASSERT(a_stall_only_when_full, in_stall, s1_valid)
  `DSPD_ASSERT_NEXT(a_fire_fills_result, fire, out_valid)
  `DSPD_ASSERT_NEXT(a_hold_keeps_position, fire && is_hold, $stable(pos[0]) && $stable(pos[1]))
  `DSPD_ASSERT_NEXT(a_last_dir_tracks, fire, last_dir == $past(s1_dir))

endmodule
